/* design/wmf5_pkg.sv */
// Shared constants and types of the weighted 5x5 median filter.
package wmf5_pkg;

   // Field and register widths.
   localparam int PIX_W       = 8;
   localparam int IMG_W_BITS  = 11;
   localparam int IMG_H_BITS  = 16;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 16;

   // Position counters: input runs past the pixel count by up to one lag.
   localparam int POS_W       = 27;
   localparam int OPOS_W      = 26;
   localparam int TOTAL_W     = 26;
   localparam int LAG_W       = 13;

   // Window geometry and the rank test.
   localparam int WIN_N       = 5;
   localparam int WIN_TAPS    = 25;
   localparam int HALF_WEIGHT = 17;
   localparam int PSUM_W      = 4;
   localparam int SUM_W       = 6;

   // Result queue.
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = 3;
   localparam int CNT_W       = FIFO_AW + 1;

   // Serial divider that rebuilds row and column after a register write.
   localparam int DIV_STEPS   = 27;
   localparam int DIV_CNT_W   = 5;

   // Register values after reset.
   localparam int RST_IMG_WIDTH  = 1024;
   localparam int RST_IMG_HEIGHT = 1024;

   typedef logic [PIX_W-1:0]      pix_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [4*PIX_W-1:0]    line_word_type;

   // Register indexes of the configuration port.
   localparam csr_addr_type CSR_IMAGE_WIDTH  = 1'b0;
   localparam csr_addr_type CSR_IMAGE_HEIGHT = 1'b1;

   // Per-result flags that travel down the pipeline.
   typedef struct packed {
      logic border;
      logic last;
   } res_tag_type;

   // One entry of the result queue.
   typedef struct packed {
      logic    last;
      pix_type pix;
   } rsp_entry_type;

   // Sample weights: 2 in the centre 3x3, 1 on the outer ring.
   localparam logic [1:0] WEIGHT [WIN_N][WIN_N] = '{
      '{2'd1, 2'd1, 2'd1, 2'd1, 2'd1},
      '{2'd1, 2'd2, 2'd2, 2'd2, 2'd1},
      '{2'd1, 2'd2, 2'd2, 2'd2, 2'd1},
      '{2'd1, 2'd2, 2'd2, 2'd2, 2'd1},
      '{2'd1, 2'd1, 2'd1, 2'd1, 2'd1}
   };

endpackage

/* design/weighted_median_filter_5x5.sv */
// Weighted 5x5 median filter over a raster pixel stream, with line memory and result queue.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_tvalid/req_tready   tdata[7:0] pixel_in, tuser[0] kind
//   rsp      out        rsp_tvalid/rsp_tready   tdata[7:0] pixel_out, tlast last_pixel
//   csr      in         csr_we                  csr_addr register index, csr_wdata value
//
// One item is taken every clock while req_tready is high; the line memory is read on
// acceptance and written back in the next cycle, with a bypass when the same column is touched
// twice in a row. A result passes the first stage, the window and the rank stages on its way
// to the output queue; the queue is eight deep and req_tready drops when results in flight
// plus queued results fill it, during a register write, and while a serial divider rebuilds
// the column and row counters for the new width. No clearing pass is needed after reset.
// Reset is synchronous and clears the counters, the window and all valid flags.
module weighted_median_filter_5x5 #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [wmf5_pkg::PIX_W-1:0]         req_tdata,   // [7:0] pixel_in
   input  logic [0:0]                         req_tuser,   // [0] kind
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [wmf5_pkg::PIX_W-1:0]         rsp_tdata,   // [7:0] pixel_out
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [wmf5_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [wmf5_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import wmf5_pkg::*;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int EXT_W   = ((COL_W > IMG_W_BITS) ? COL_W : IMG_W_BITS) + 1;
   localparam int RST_EFF_W = (RST_IMG_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMG_WIDTH;

   // Configuration registers and derived sizes.
   logic [IMG_W_BITS-1:0] img_width_ff;
   logic [IMG_H_BITS-1:0] img_height_ff;
   logic [IMG_W_BITS-1:0] eff_w;
   logic [IMG_H_BITS-1:0] eff_h;
   logic [LAG_W-1:0]      lag;
   logic [TOTAL_W-1:0]    total_ff, total_in;

   // Position counters.
   logic [POS_W-1:0]  in_pos_ff, in_pos_in;
   logic [COL_W-1:0]  col_in_ff, col_in_in;
   logic [OPOS_W-1:0] out_pos_ff, out_pos_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [OPOS_W-1:0] out_row_ff, out_row_in;

   // Divider state.
   logic                  busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]  div_step_ff, div_step_in;
   logic [POS_W-1:0]      div_p_ff, div_p_in;
   logic [POS_W-1:0]      div_q_ff, div_q_in;
   logic [IMG_W_BITS-1:0] rem_p_ff, rem_p_in;
   logic [IMG_W_BITS-1:0] rem_q_ff, rem_q_in;
   logic [IMG_W_BITS:0]   trial_p, trial_q, diff_p, diff_q;
   logic                  ge_p, ge_q, div_done;

   // Acceptance decode.
   logic        accept, drain, step, produce, res_last, row_ok, col_ok, col_wrap, out_wrap;
   res_tag_type tag_now;

   // Line memory and the first stage.
   line_word_type line_mem [MAX_WIDTH];
   line_word_type rd_word_ff, fwd_word_ff, s1_word, s1_word_new;
   logic          fwd_ff;
   logic          s1_valid_ff, s1_produce_ff;
   logic [COL_W-1:0] s1_col_ff;
   pix_type       s1_pix_ff;
   res_tag_type   s1_tag_ff;

   // Window and rank pipeline.
   pix_type     win_ff [WIN_TAPS];
   logic        win_res_ff;
   res_tag_type win_tag_ff;
   logic [PSUM_W-1:0] psum_in [WIN_TAPS][WIN_N];
   logic [PSUM_W-1:0] s2_psum_ff [WIN_TAPS][WIN_N];
   pix_type     s2_val_ff [WIN_TAPS];
   pix_type     s2_centre_ff;
   logic        s2_valid_ff;
   res_tag_type s2_tag_ff;
   logic [WIN_TAPS-1:0] ok_in, s3_ok_ff;
   pix_type     s3_val_ff [WIN_TAPS];
   pix_type     s3_centre_ff;
   logic        s3_valid_ff;
   res_tag_type s3_tag_ff;
   pix_type     gmin_in [WIN_N];
   pix_type     s4_gmin_ff [WIN_N];
   pix_type     s4_centre_ff;
   logic        s4_valid_ff;
   res_tag_type s4_tag_ff;
   pix_type     res_pix;

   // Result queue and credit count.
   rsp_entry_type      fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   fifo_cnt_ff, fifo_cnt_in;
   logic [CNT_W-1:0]   credit_ff, credit_in;
   logic               rsp_hs;

   // Effective width, height, lag and pixel count.
   always_comb begin
      if (img_width_ff == '0) begin
         eff_w = IMG_W_BITS'(1);
      end else if (32'(img_width_ff) > MAX_WIDTH) begin
         eff_w = IMG_W_BITS'(MAX_WIDTH);
      end else begin
         eff_w = img_width_ff;
      end
      eff_h    = (img_height_ff == '0) ? IMG_H_BITS'(1) : img_height_ff;
      lag      = LAG_W'({eff_w, 1'b0}) + LAG_W'(2);
      total_in = TOTAL_W'(POS_W'(eff_w) * POS_W'(eff_h));
   end

   // Configuration registers and the registered pixel count.
   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= IMG_W_BITS'(RST_IMG_WIDTH);
         img_height_ff <= IMG_H_BITS'(RST_IMG_HEIGHT);
         total_ff      <= TOTAL_W'(RST_EFF_W * RST_IMG_HEIGHT);
      end else begin
         total_ff <= total_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_IMAGE_WIDTH:  img_width_ff  <= csr_wdata[IMG_W_BITS-1:0];
               CSR_IMAGE_HEIGHT: img_height_ff <= csr_wdata[IMG_H_BITS-1:0];
               default:          img_height_ff <= img_height_ff;
            endcase
         end
      end
   end

   // Restoring divider: input position modulo width, output position by width.
   always_comb begin
      trial_p  = {rem_p_ff, div_p_ff[POS_W-1]};
      trial_q  = {rem_q_ff, div_q_ff[POS_W-1]};
      diff_p   = trial_p - {1'b0, eff_w};
      diff_q   = trial_q - {1'b0, eff_w};
      ge_p     = trial_p >= {1'b0, eff_w};
      ge_q     = trial_q >= {1'b0, eff_w};
      div_done = busy_ff && (div_step_ff == DIV_CNT_W'(DIV_STEPS));

      busy_in     = busy_ff;
      div_step_in = div_step_ff;
      div_p_in    = div_p_ff;
      div_q_in    = div_q_ff;
      rem_p_in    = rem_p_ff;
      rem_q_in    = rem_q_ff;
      priority if (csr_we) begin
         busy_in     = 1'b1;
         div_step_in = '0;
         div_p_in    = in_pos_ff;
         div_q_in    = {1'b0, out_pos_ff};
         rem_p_in    = '0;
         rem_q_in    = '0;
      end else if (div_done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         div_step_in = div_step_ff + DIV_CNT_W'(1);
         div_p_in    = {div_p_ff[POS_W-2:0], 1'b0};
         div_q_in    = {div_q_ff[POS_W-2:0], ge_q};
         rem_p_in    = ge_p ? diff_p[IMG_W_BITS-1:0] : trial_p[IMG_W_BITS-1:0];
         rem_q_in    = ge_q ? diff_q[IMG_W_BITS-1:0] : trial_q[IMG_W_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         div_step_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         div_step_ff <= div_step_in;
      end
      div_p_ff <= div_p_in;
      div_q_ff <= div_q_in;
      rem_p_ff <= rem_p_in;
      rem_q_ff <= rem_q_in;
   end

   // Acceptance: what the incoming transaction does to the stream.
   assign req_tready = !busy_ff && !csr_we && (credit_ff < CNT_W'(FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign drain      = in_pos_ff >= POS_W'(total_ff);
   assign step       = accept && (drain || !req_tuser[0]);
   assign produce    = step && (in_pos_ff >= POS_W'(lag));
   assign res_last   = (POS_W'(out_pos_ff) + POS_W'(1)) >= POS_W'(total_ff);
   assign row_ok     = (out_row_ff >= OPOS_W'(2)) &&
                       ((POS_W'(out_row_ff) + POS_W'(2)) < POS_W'(eff_h));
   assign col_ok     = (out_col_ff >= COL_W'(2)) &&
                       ((EXT_W'(out_col_ff) + EXT_W'(2)) < EXT_W'(eff_w));
   assign col_wrap   = (EXT_W'(col_in_ff) + EXT_W'(1)) == EXT_W'(eff_w);
   assign out_wrap   = (EXT_W'(out_col_ff) + EXT_W'(1)) == EXT_W'(eff_w);
   assign tag_now    = '{border: !(row_ok && col_ok), last: res_last};

   // Position counters; the divider result replaces them after a register write.
   always_comb begin
      in_pos_in  = in_pos_ff;
      col_in_in  = col_in_ff;
      out_pos_in = out_pos_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      priority if (div_done) begin
         col_in_in  = COL_W'(rem_p_ff);
         out_col_in = COL_W'(rem_q_ff);
         out_row_in = div_q_ff[OPOS_W-1:0];
      end else if (step) begin
         if (produce && res_last) begin
            in_pos_in  = '0;
            col_in_in  = '0;
            out_pos_in = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            in_pos_in = in_pos_ff + POS_W'(1);
            col_in_in = col_wrap ? '0 : col_in_ff + COL_W'(1);
            if (produce) begin
               out_pos_in = out_pos_ff + OPOS_W'(1);
               if (out_wrap) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + OPOS_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pos_ff  <= '0;
         col_in_ff  <= '0;
         out_pos_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_pos_ff  <= in_pos_in;
         col_in_ff  <= col_in_in;
         out_pos_ff <= out_pos_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // Line memory: four stored rows per column, read on acceptance, written back in the next cycle.
   always_ff @(posedge clock) begin
      rd_word_ff <= line_mem[col_in_ff];
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= s1_word_new;
      end
   end

   // The word seen by the first stage, bypassed when the previous item wrote that column.
   assign s1_word     = fwd_ff ? fwd_word_ff : rd_word_ff;
   assign s1_word_new = {s1_word[3*PIX_W-1:0], s1_pix_ff};

   // First stage registers and the bypass.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= step;
         fwd_ff      <= s1_valid_ff && (s1_col_ff == col_in_ff);
      end
      s1_col_ff     <= col_in_ff;
      s1_pix_ff     <= drain ? '0 : req_tdata;
      s1_produce_ff <= produce;
      s1_tag_ff     <= tag_now;
      fwd_word_ff   <= s1_word_new;
   end

   // Window: each row shifts left, the fresh column enters on the right.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_TAPS; i++) begin
            win_ff[i] <= '0;
         end
         win_res_ff <= 1'b0;
      end else begin
         win_res_ff <= s1_valid_ff && s1_produce_ff;
         if (s1_valid_ff) begin
            for (int r = 0; r < WIN_N; r++) begin
               for (int k = 0; k < WIN_N - 1; k++) begin
                  win_ff[r*WIN_N + k] <= win_ff[r*WIN_N + k + 1];
               end
            end
            win_ff[0*WIN_N + 4] <= s1_word[4*PIX_W-1:3*PIX_W];
            win_ff[1*WIN_N + 4] <= s1_word[3*PIX_W-1:2*PIX_W];
            win_ff[2*WIN_N + 4] <= s1_word[2*PIX_W-1:PIX_W];
            win_ff[3*WIN_N + 4] <= s1_word[PIX_W-1:0];
            win_ff[4*WIN_N + 4] <= s1_pix_ff;
         end
      end
      win_tag_ff <= s1_tag_ff;
   end

   // Rank stage one: weighted count per candidate and window row.
   always_comb begin
      for (int a = 0; a < WIN_TAPS; a++) begin
         for (int r = 0; r < WIN_N; r++) begin
            psum_in[a][r] = '0;
            for (int c = 0; c < WIN_N; c++) begin
               if (win_ff[r*WIN_N + c] <= win_ff[a]) begin
                  psum_in[a][r] = psum_in[a][r] + PSUM_W'(WEIGHT[r][c]);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= win_res_ff;
      end
      s2_psum_ff   <= psum_in;
      s2_val_ff    <= win_ff;
      s2_centre_ff <= win_ff[2*WIN_N + 2];
      s2_tag_ff    <= win_tag_ff;
   end

   // Rank stage two: a candidate qualifies when its weighted count reaches half.
   always_comb begin
      logic [SUM_W-1:0] sum;
      for (int a = 0; a < WIN_TAPS; a++) begin
         sum = '0;
         for (int r = 0; r < WIN_N; r++) begin
            sum = sum + SUM_W'(s2_psum_ff[a][r]);
         end
         ok_in[a] = sum >= SUM_W'(HALF_WEIGHT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_ok_ff     <= ok_in;
      s3_val_ff    <= s2_val_ff;
      s3_centre_ff <= s2_centre_ff;
      s3_tag_ff    <= s2_tag_ff;
   end

   // Rank stage three: smallest qualifying value in each group of five.
   always_comb begin
      for (int g = 0; g < WIN_N; g++) begin
         gmin_in[g] = '1;
         for (int k = 0; k < WIN_N; k++) begin
            if (s3_ok_ff[g*WIN_N + k] && (s3_val_ff[g*WIN_N + k] < gmin_in[g])) begin
               gmin_in[g] = s3_val_ff[g*WIN_N + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_gmin_ff   <= gmin_in;
      s4_centre_ff <= s3_centre_ff;
      s4_tag_ff    <= s3_tag_ff;
   end

   // Final minimum, or the centre sample for a border pixel.
   always_comb begin
      pix_type m;
      m = '1;
      for (int g = 0; g < WIN_N; g++) begin
         if (s4_gmin_ff[g] < m) begin
            m = s4_gmin_ff[g];
         end
      end
      res_pix = s4_tag_ff.border ? s4_centre_ff : m;
   end

   // Result queue; credits count results in flight plus those queued.
   assign rsp_hs      = rsp_tvalid && rsp_tready;
   assign fifo_cnt_in = fifo_cnt_ff + CNT_W'(s4_valid_ff) - CNT_W'(rsp_hs);
   assign credit_in   = credit_ff + CNT_W'(accept && produce) - CNT_W'(rsp_hs);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         credit_ff   <= '0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         credit_ff   <= credit_in;
         if (s4_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (rsp_hs) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
      end
      if (s4_valid_ff) begin
         fifo_mem[wr_ptr_ff] <= '{last: s4_tag_ff.last, pix: res_pix};
      end
   end

   assign rsp_tvalid = fifo_cnt_ff != '0;
   assign rsp_tdata  = fifo_mem[rd_ptr_ff].pix;
   assign rsp_tlast  = fifo_mem[rd_ptr_ff].last;

`ifndef SYNTHESIS
   // Queued results never exceed the credits, and credits never exceed the queue.
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      (credit_ff <= CNT_W'(FIFO_DEPTH)) && (fifo_cnt_ff <= credit_ff))
      else $error("result credits out of range");

   // The last pixel of an image returns every position to the start.
   a_image_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && produce && res_last) |=>
         (in_pos_ff == '0) && (out_pos_ff == '0) && (col_in_ff == '0) && (out_row_ff == '0))
      else $error("positions not cleared after last pixel");

   // Outside a recompute the column counters lie inside the row.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (EXT_W'(col_in_ff) < EXT_W'(eff_w)) && (EXT_W'(out_col_ff) < EXT_W'(eff_w)))
      else $error("column counter beyond image width");

   // A register write starts a recompute, during which no transaction is taken.
   a_csr_recompute: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> busy_ff && !accept)
      else $error("transaction accepted during recompute");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the weighted 5x5 median filter stream block.
`timescale 1ns / 1ps

module tb_top;
   import wmf5_pkg::*;

   localparam int MAX_W          = 1024;
   localparam int RANK_HALF      = 17;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 850;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_FLUSH = 1'b1
   } item_kind_t;

   typedef enum int {
      PAT_NOISE,
      PAT_LEVELS,
      PAT_EXTREMES,
      PAT_NARROW
   } pix_pattern_t;

   typedef struct packed {
      item_kind_t kind;
      pix_type    pix;
   } px_item_t;

   typedef struct packed {
      pix_type pix;
      logic    last;
   } px_result_t;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata  = '0;   // [7:0] pixel_in
   logic [0:0]            req_tuser  = '0;   // [0] kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIX_W-1:0]      rsp_tdata;         // [7:0] pixel_out
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   weighted_median_filter_5x5 #(
      .MAX_WIDTH (MAX_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the filter state, the registers and the traffic queues.
   bit [IMG_W_BITS-1:0] cfg_width  = RST_IMG_WIDTH;
   bit [IMG_H_BITS-1:0] cfg_height = RST_IMG_HEIGHT;
   pix_type             row_mem [4][MAX_W];
   pix_type             nbhd [5][5];
   int unsigned         in_pos  = 0;
   int unsigned         out_pos = 0;

   px_item_t    pending_px [$];
   px_result_t  expected_px [$];
   int unsigned items_waiting = 0;
   int unsigned items_fed     = 0;
   int unsigned mismatches    = 0;
   int unsigned rsp_seen      = 0;
   logic        calm          = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_W) return MAX_W;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   // Smallest sample whose cumulative weight reaches half of the total.
   function automatic pix_type weighted_rank();
      int unsigned hist [256];
      int unsigned acc;
      for (int r = 0; r < 5; r++) begin
         for (int c = 0; c < 5; c++) begin
            hist[nbhd[r][c]] += (r >= 1 && r <= 3 && c >= 1 && c <= 3) ? 2 : 1;
         end
      end
      acc = 0;
      for (int v = 0; v < 256; v++) begin
         acc += hist[v];
         if (acc >= RANK_HALF) return pix_type'(v);
      end
      return '1;
   endfunction

   // Advances the shadow filter by one accepted transaction and queues any result.
   function automatic void advance_filter(px_item_t item);
      int unsigned w, h, total, lag, col, p, q;
      pix_type     sample;
      pix_type     fresh [5];
      px_result_t  res;
      w      = eff_width();
      h      = eff_height();
      total  = w * h;
      lag    = 2 * w + 2;
      sample = item.pix;
      // Once every pixel is in, any transaction drains a zero sample.
      if (in_pos >= total) sample = '0;
      else if (item.kind == KIND_FLUSH) return;
      col      = in_pos % w;
      fresh[0] = row_mem[3][col];
      fresh[1] = row_mem[2][col];
      fresh[2] = row_mem[1][col];
      fresh[3] = row_mem[0][col];
      fresh[4] = sample;
      for (int k = 0; k < 4; k++) row_mem[3-k][col] = fresh[k+1];
      for (int r = 0; r < 5; r++) begin
         for (int k = 0; k < 4; k++) nbhd[r][k] = nbhd[r][k+1];
         nbhd[r][4] = fresh[r];
      end
      p = in_pos;
      in_pos++;
      if (p < lag) return;
      q = out_pos;
      out_pos++;
      if (q / w >= 2 && q / w + 2 < h && q % w >= 2 && q % w + 2 < w)
         res.pix = weighted_rank();
      else
         res.pix = nbhd[2][2];
      res.last = (q + 1 >= total);
      expected_px.push_back(res);
      if (res.last) begin
         in_pos  = 0;
         out_pos = 0;
      end
   endfunction

   // Idle length for either side: mostly short, now and then long, none while calm.
   function automatic int unsigned pick_idle();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic pix_type pick_pixel(pix_pattern_t pat);
      case (pat)
         PAT_LEVELS: begin
            case ($urandom_range(0, 3))
               0:       return 8'h00;
               1:       return 8'h80;
               2:       return 8'h81;
               default: return 8'hFF;
            endcase
         end
         PAT_EXTREMES: return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
         PAT_NARROW:   return pix_type'(100 + $urandom_range(0, 3));
         default:      return pix_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic mismatch(string msg);
      mismatches++;
      if (mismatches <= 200) $display("tb_top: mismatch: %s", msg);
   endtask

   task automatic queue_item(item_kind_t kind, pix_type pix);
      px_item_t item;
      item.kind = kind;
      item.pix  = pix;
      pending_px.push_back(item);
      items_waiting++;
   endtask

   // Waits until every transaction is taken and every result has come back.
   task automatic settle();
      do @(posedge clock); while (items_waiting != 0 || expected_px.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_addr_type idx, logic [CSR_DATA_W-1:0] value);
      settle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      if (idx == CSR_IMAGE_WIDTH) cfg_width = value[IMG_W_BITS-1:0];
      else cfg_height = value[IMG_H_BITS-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Queues the rest of the current image, at most limit transactions, from the
   // shadow positions: pixels while the image is incomplete, then drain ticks.
   task automatic feed_image(int unsigned limit, pix_pattern_t pat);
      int unsigned w, h, total, lag, n_items, n_pix;
      settle();
      w       = eff_width();
      h       = eff_height();
      total   = w * h;
      lag     = 2 * w + 2;
      n_items = ((in_pos < lag) ? lag - in_pos : 0) + ((out_pos < total) ? total - out_pos : 1);
      n_pix   = (in_pos < total) ? total - in_pos : 0;
      if (n_pix > n_items) n_pix = n_items;
      if (n_items > limit) n_items = limit;
      for (int unsigned k = 0; k < n_items; k++) begin
         if (k < n_pix) begin
            // A stray flush inside an incomplete image is ignored by the block.
            if ($urandom_range(0, 19) == 0) queue_item(KIND_FLUSH, pix_type'($urandom_range(0, 255)));
            queue_item(KIND_PIXEL, pick_pixel(pat));
         end else begin
            queue_item(($urandom_range(0, 3) == 0) ? KIND_PIXEL : KIND_FLUSH,
                       pix_type'($urandom_range(0, 255)));
         end
      end
      items_fed += n_items;
   endtask

   // Input driver: one transaction at a time from the pending queue, with random gaps.
   px_item_t    drv_item;
   int unsigned drv_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         drv_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_filter(drv_item);
            items_waiting--;
         end
         if (!req_tvalid || req_tready) begin
            if (drv_gap > 0 || pending_px.size() == 0) begin
               if (drv_gap > 0) drv_gap--;
               req_tvalid <= 1'b0;
            end else begin
               drv_item = pending_px.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= drv_item.pix;
               req_tuser  <= drv_item.kind;
               drv_gap = pick_idle();
            end
         end
      end
   end

   // Result monitor with random back-pressure.
   int unsigned mon_stall = 0;
   px_result_t  mon_want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mon_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_px.size() == 0) begin
               mismatch($sformatf("result %0d unexpected: pixel %0d last %0b",
                                  rsp_seen, rsp_tdata, rsp_tlast));
            end else begin
               mon_want = expected_px.pop_front();
               if (rsp_tdata !== mon_want.pix)
                  mismatch($sformatf("result %0d pixel %0d, expected %0d",
                                     rsp_seen, rsp_tdata, mon_want.pix));
               if (rsp_tlast !== mon_want.last)
                  mismatch($sformatf("result %0d last %0b, expected %0b",
                                     rsp_seen, rsp_tlast, mon_want.last));
            end
            rsp_seen++;
         end
         if (mon_stall > 0) begin
            mon_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            mon_stall = pick_idle();
         end
      end
   end

   // Stretches with no idling on either side.
   int unsigned calm_left = 0;

   always @(posedge clock) begin
      if (calm_left == 0) begin
         calm <= ($urandom_range(0, 3) == 0);
         calm_left = $urandom_range(50, 400);
      end else begin
         calm_left--;
      end
   end

   // Watchdog: ends the run after too long without any transaction.
   int unsigned quiet = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Stimulus sequence.
   initial begin
      int unsigned             w, h, start_fed, full_len, roll;
      logic [CSR_DATA_W-1:0]   wval;
      pix_pattern_t            pat;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Width zero with high bits set, height zero: a one-pixel image. The leading
      // flush is ignored and the drain ticks may carry pixels that are dropped.
      write_reg(CSR_IMAGE_WIDTH, 16'hF800);
      write_reg(CSR_IMAGE_HEIGHT, 16'h0000);
      queue_item(KIND_FLUSH, 8'hFF);
      feed_image('1, PAT_EXTREMES);

      // Smallest image with an interior pixel, full of ties between the extremes.
      write_reg(CSR_IMAGE_WIDTH, 16'd5);
      write_reg(CSR_IMAGE_HEIGHT, 16'd5);
      feed_image('1, PAT_EXTREMES);

      // Tallest height, then cut short below the rows already produced.
      write_reg(CSR_IMAGE_WIDTH, 16'd1);
      write_reg(CSR_IMAGE_HEIGHT, 16'hFFFF);
      feed_image(40, PAT_NOISE);
      write_reg(CSR_IMAGE_HEIGHT, 16'd20);
      feed_image('1, PAT_NOISE);

      // Height raised part way through an image.
      write_reg(CSR_IMAGE_WIDTH, 16'd6);
      write_reg(CSR_IMAGE_HEIGHT, 16'd3);
      feed_image(10, PAT_LEVELS);
      write_reg(CSR_IMAGE_HEIGHT, 16'd6);
      feed_image('1, PAT_LEVELS);

      // Width beyond the maximum, a single full-width row.
      write_reg(CSR_IMAGE_WIDTH, 16'd2047);
      write_reg(CSR_IMAGE_HEIGHT, 16'd0);
      feed_image('1, PAT_NOISE);

      // Random images of mostly small sizes, some of them cut or stretched midway.
      start_fed = items_fed;
      while (items_fed - start_fed < RANDOM_ITEMS) begin
         if (eff_width() > 40 || $urandom_range(0, 9) < 4) begin
            roll = $urandom_range(0, 19);
            if (roll < 14) w = $urandom_range(5, 12);
            else if (roll < 17) w = $urandom_range(1, 4);
            else w = $urandom_range(13, 40);
            roll = $urandom_range(0, 19);
            if (roll < 14) h = $urandom_range(5, 9);
            else if (roll < 17) h = $urandom_range(0, 4);
            else h = $urandom_range(10, 16);
            wval = w;
            wval[CSR_DATA_W-1:IMG_W_BITS] = $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 0) begin
               write_reg(CSR_IMAGE_WIDTH, wval);
               write_reg(CSR_IMAGE_HEIGHT, h[CSR_DATA_W-1:0]);
            end else begin
               write_reg(CSR_IMAGE_HEIGHT, h[CSR_DATA_W-1:0]);
               write_reg(CSR_IMAGE_WIDTH, wval);
            end
         end
         pat = pix_pattern_t'($urandom_range(0, 3));
         if ($urandom_range(0, 9) == 0) begin
            // Broken image: stop part way, change the height, then finish it.
            full_len = eff_width() * eff_height() + 2 * eff_width() + 2;
            feed_image($urandom_range(1, full_len), pat);
            if ($urandom_range(0, 2) == 0) begin
               wval = eff_width();
               wval[CSR_DATA_W-1:IMG_W_BITS] = $urandom_range(0, 31);
               write_reg(CSR_IMAGE_WIDTH, wval);
            end
            write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'($urandom_range(1, 12)));
         end
         feed_image('1, pat);
      end

      settle();
      if (mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
